@@ src/multi_waveform_nco_unit_macros.svh @@
// Assertion macros for the multi-waveform oscillator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MULTI_WAVEFORM_NCO_UNIT_MACROS_SVH
`define MULTI_WAVEFORM_NCO_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define MWNCO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwnco assertion failed");

`define MWNCO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwnco assertion failed");

`else

`define MWNCO_ASSERT_NOW(label, ante, cons)

`define MWNCO_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/mwnco_pkg.sv @@
`default_nettype none

package mwnco_pkg;

    localparam int DEF_PHASE_BITS = 32;
    localparam int DEF_SINE_TABLE_ADDR_BITS = 10;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int IN_PHASE_BITS = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int WAVEFORM_BITS = 2;
    localparam int CMD_BITS = 2;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WAVEFORM   = 1'b0,
        REG_PHASE_STEP = 1'b1
    } cfg_reg_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NEXT = 2'd0,
        CMD_EVAL = 2'd1,
        CMD_LOAD = 2'd2
    } cmd_t;

    typedef enum logic [WAVEFORM_BITS-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAW      = 2'd3
    } wave_t;

    // shift-subtract quotient, evaluated only while building the table
    function automatic longint unsigned quotient(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned sine_entry(
        input int unsigned j,
        input int unsigned addr_bits,
        input int unsigned sample_bits
    );
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint sum;
        longint maxv;
        longint r;
        x = (HALF_PI_Q30 * longint'(j)) >> addr_bits;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        maxv = (longint'(1) << (sample_bits - 1)) - 1;
        for (int n = 1; n <= 10; n++)
        begin
            den = 64'((2 * n) * (2 * n + 1));
            term = quotient((term * x2) >> 30, den);
            if ((n & 1) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (sum * maxv + (longint'(1) << 29)) >>> 30;
        if (r > maxv)
        begin
            r = maxv;
        end
        return longint'(r);
    endfunction

endpackage

`default_nettype wire

@@ src/mwnco_phase.sv @@
`default_nettype none

module mwnco_phase #(
    parameter int PHASE_BITS = mwnco_pkg::DEF_PHASE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [mwnco_pkg::CMD_BITS-1:0]       cmd,
    input  wire logic [PHASE_BITS-1:0]                pv_aligned,
    input  wire logic [PHASE_BITS-1:0]                step,
    input  wire logic                                 s1_take,
    output logic                                      s1_valid,
    output logic [PHASE_BITS-1:0]                     s1_phase
);

    logic                  acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [PHASE_BITS-1:0] s1_phase_reg;
    logic [PHASE_BITS-1:0] s1_phase_next;
    logic                  accept;

    assign in_stall = s1_valid_reg && !s1_take;
    assign accept   = in_valid && !in_stall;
    assign acc_reg  = accept;

    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        s1_phase_next  = s1_phase_reg;
        s1_valid_next  = s1_take ? 1'b0 : s1_valid_reg;
        if (acc_reg)
        begin
            case (cmd)
                mwnco_pkg::CMD_NEXT:
                begin
                    s1_phase_next  = phase_acc_reg + pv_aligned;
                    s1_valid_next  = 1'b1;
                    phase_acc_next = phase_acc_reg + step;
                end
                mwnco_pkg::CMD_EVAL:
                begin
                    s1_phase_next = pv_aligned;
                    s1_valid_next = 1'b1;
                end
                mwnco_pkg::CMD_LOAD:
                begin
                    phase_acc_next = pv_aligned;
                end
                default:
                begin
                    // drop the request
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_phase_reg <= s1_phase_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_phase = s1_phase_reg;

endmodule

`default_nettype wire

@@ src/mwnco_wave.sv @@
`default_nettype none

module mwnco_wave #(
    parameter int PHASE_BITS           = mwnco_pkg::DEF_PHASE_BITS,
    parameter int SINE_TABLE_ADDR_BITS = mwnco_pkg::DEF_SINE_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS          = mwnco_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [mwnco_pkg::WAVEFORM_BITS-1:0]   waveform,
    input  wire logic                                  s1_valid,
    input  wire logic [PHASE_BITS-1:0]                 s1_phase,
    output logic                                       s1_take,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]              sample
);

    localparam int TABLE_N   = 1 << SINE_TABLE_ADDR_BITS;
    localparam int ROM_DEPTH = TABLE_N + 1;
    localparam int IDX_BITS  = SINE_TABLE_ADDR_BITS + 1;
    localparam int EXT_BITS  = (PHASE_BITS > SAMPLE_BITS + 1) ? PHASE_BITS : SAMPLE_BITS + 1;

    typedef logic [SAMPLE_BITS-2:0] rom_word_t;
    typedef rom_word_t rom_image_t [ROM_DEPTH];

    function automatic rom_image_t build_rom();
        rom_image_t img;
        for (int j = 0; j < ROM_DEPTH; j++)
        begin
            img[j] = rom_word_t'(mwnco_pkg::sine_entry(j, SINE_TABLE_ADDR_BITS, SAMPLE_BITS));
        end
        return img;
    endfunction

    localparam rom_image_t SINE_ROM = build_rom();

    localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [1:0]                       quadrant;
    logic [SINE_TABLE_ADDR_BITS-1:0]  tab_k;
    logic [IDX_BITS-1:0]              rom_index;
    logic [EXT_BITS-1:0]              phase_ext;
    logic [SAMPLE_BITS-1:0]           saw_top;
    logic [SAMPLE_BITS:0]             tri_top;
    logic [SAMPLE_BITS-1:0]           tri_low;
    logic                             tri_sat;
    logic signed [SAMPLE_BITS-1:0]    saw_val;
    logic signed [SAMPLE_BITS-1:0]    tri_val;
    logic signed [SAMPLE_BITS-1:0]    sq_val;
    logic signed [SAMPLE_BITS-1:0]    alt_val;
    logic                             s2_ready;
    logic                             out_free;

    logic                             s2_valid_reg;
    logic                             s2_valid_next;
    rom_word_t                        rom_data_reg;
    logic                             s2_neg_reg;
    logic                             s2_sine_reg;
    logic signed [SAMPLE_BITS-1:0]    s2_alt_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic signed [SAMPLE_BITS-1:0]    sample_reg;
    logic signed [SAMPLE_BITS-1:0]    sample_next;

    assign quadrant  = s1_phase[PHASE_BITS-1 -: 2];
    assign tab_k     = s1_phase[PHASE_BITS-3 -: SINE_TABLE_ADDR_BITS];
    assign rom_index = quadrant[0] ? (IDX_BITS'(TABLE_N) - {1'b0, tab_k}) : {1'b0, tab_k};

    assign phase_ext = EXT_BITS'(s1_phase) << (EXT_BITS - PHASE_BITS);
    assign saw_top   = phase_ext[EXT_BITS-1 -: SAMPLE_BITS];
    assign tri_top   = phase_ext[EXT_BITS-1 -: SAMPLE_BITS+1];
    assign saw_val   = {~saw_top[SAMPLE_BITS-1], saw_top[SAMPLE_BITS-2:0]};
    assign tri_low   = tri_top[SAMPLE_BITS] ? tri_top[SAMPLE_BITS-1:0]
                                            : (~tri_top[SAMPLE_BITS-1:0] + 1'b1);
    assign tri_sat   = !tri_top[SAMPLE_BITS] && (tri_top[SAMPLE_BITS-1:0] == '0);
    assign tri_val   = tri_sat ? MAXV : {~tri_low[SAMPLE_BITS-1], tri_low[SAMPLE_BITS-2:0]};

    always_comb
    begin
        if (s1_phase[PHASE_BITS-2:0] == '0)
        begin
            sq_val = '0;
        end
        else if (s1_phase[PHASE_BITS-1])
        begin
            sq_val = MINV;
        end
        else
        begin
            sq_val = MAXV;
        end
    end

    always_comb
    begin
        case (waveform)
            mwnco_pkg::WAVE_SQUARE:   alt_val = sq_val;
            mwnco_pkg::WAVE_TRIANGLE: alt_val = tri_val;
            mwnco_pkg::WAVE_SAW:      alt_val = saw_val;
            default:                  alt_val = '0;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_take  = s1_valid && s2_ready;

    assign s2_valid_next  = s2_ready ? s1_valid : s2_valid_reg;
    assign out_valid_next = out_free ? s2_valid_reg : out_valid_reg;

    always_comb
    begin
        if (!s2_sine_reg)
        begin
            sample_next = s2_alt_reg;
        end
        else if (s2_neg_reg)
        begin
            sample_next = -$signed({1'b0, rom_data_reg});
        end
        else
        begin
            sample_next = $signed({1'b0, rom_data_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            rom_data_reg <= SINE_ROM[rom_index];
            s2_neg_reg   <= quadrant[1];
            s2_sine_reg  <= (waveform == mwnco_pkg::WAVE_SINE);
            s2_alt_reg   <= alt_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_free)
        begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

@@ src/multi_waveform_nco_unit.sv @@
// A NEXT or EVAL request passes the phase, sine ROM and output registers.
// Throughput: one request per cycle while in_stall is low; the phase register,
// and the sine ROM read port and the output register each take one request per cycle.
// Reset (rst_n, asynchronous, active low) clears the phase accumulator, the
// waveform and phase step registers and all valid flags.
`default_nettype none

`include "multi_waveform_nco_unit_macros.svh"

module multi_waveform_nco_unit #(
    parameter int PHASE_BITS           = mwnco_pkg::DEF_PHASE_BITS,
    parameter int SINE_TABLE_ADDR_BITS = mwnco_pkg::DEF_SINE_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS          = mwnco_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [mwnco_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [mwnco_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [mwnco_pkg::CMD_BITS-1:0]         cmd,
    input  wire logic [mwnco_pkg::IN_PHASE_BITS-1:0]    phase_value,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [SAMPLE_BITS-1:0]               sample
);

    logic [mwnco_pkg::WAVEFORM_BITS-1:0] waveform_reg;
    logic [PHASE_BITS-1:0]               step_reg;
    logic [PHASE_BITS-1:0]               pv_aligned;
    logic [PHASE_BITS-1:0]               cfg_aligned;
    logic                                s1_valid;
    logic [PHASE_BITS-1:0]               s1_phase;
    logic                                s1_take;
    logic                                in_accept;

    generate
        if (PHASE_BITS >= mwnco_pkg::IN_PHASE_BITS)
        begin : g_wide_phase
            assign pv_aligned  = PHASE_BITS'(phase_value) << (PHASE_BITS - mwnco_pkg::IN_PHASE_BITS);
            assign cfg_aligned = PHASE_BITS'(cfg_data) << (PHASE_BITS - mwnco_pkg::IN_PHASE_BITS);
        end
        else
        begin : g_narrow_phase
            assign pv_aligned  = phase_value[mwnco_pkg::IN_PHASE_BITS-1 -: PHASE_BITS];
            assign cfg_aligned = cfg_data[mwnco_pkg::CFG_DATA_BITS-1 -: PHASE_BITS];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= '0;
            step_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mwnco_pkg::REG_WAVEFORM:   waveform_reg <= cfg_data[mwnco_pkg::WAVEFORM_BITS-1:0];
                mwnco_pkg::REG_PHASE_STEP: step_reg     <= cfg_aligned;
                default:
                begin
                    // drop the write
                end
            endcase
        end
    end

    mwnco_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .pv_aligned (pv_aligned),
        .step       (step_reg),
        .s1_take    (s1_take),
        .s1_valid   (s1_valid),
        .s1_phase   (s1_phase)
    );

    mwnco_wave #(
        .PHASE_BITS           (PHASE_BITS),
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
        .SAMPLE_BITS          (SAMPLE_BITS)
    ) u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .waveform  (waveform_reg),
        .s1_valid  (s1_valid),
        .s1_phase  (s1_phase),
        .s1_take   (s1_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

    assign in_accept = in_valid && !in_stall;

    `MWNCO_ASSERT_NEXT(a_eval_phase, in_accept && cmd == mwnco_pkg::CMD_EVAL, s1_valid && s1_phase == $past(pv_aligned))
    `MWNCO_ASSERT_NEXT(a_next_valid, in_accept && cmd == mwnco_pkg::CMD_NEXT, s1_valid)
    `MWNCO_ASSERT_NOW(a_take_valid, s1_take, s1_valid && !in_stall)

endmodule

`default_nettype wire
